// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the key debounce RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define KDB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define KDB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/kdb_pkg.sv
// ----------------------------------------------------------------------------
// kdb_pkg
// Types and codes of the key debounce unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kdb_pkg;

	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam int unsigned CFG_DATA_BITS  = 20;

	localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_COUNT = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TICK_MS        = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_HOLD_MS    = 2'd2;

	localparam logic [7:0]  DEBOUNCE_COUNT_RST = 8'd3;
	localparam logic [9:0]  TICK_MS_RST        = 10'd20;
	localparam logic [19:0] MAX_HOLD_MS_RST    = 20'd60000;

	typedef enum logic [2:0] {
		ST_IDLE        = 3'd0,
		ST_DEB_PRESS   = 3'd1,
		ST_PRESSED     = 3'd2,
		ST_DEB_RELEASE = 3'd3,
		ST_RELEASED    = 3'd4
	} kdb_state_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2,
		EV_TIMEOUT = 2'd3
	} kdb_event_t;

	typedef struct packed {
		logic [7:0]  debounce_count;
		logic [9:0]  tick_ms;
		logic [19:0] max_hold_ms;
	} kdb_cfg_t;

	typedef struct packed {
		kdb_state_t fsm;
		logic [7:0] stable_run;
		logic       held_level;
		logic       timeout_raised;
	} kdb_ctl_t;

	typedef struct packed {
		kdb_event_t event_code;
		logic       debounced_level;
	} kdb_res_t;

endpackage

`default_nettype wire

// File: rtl/kdb_step.sv
// ----------------------------------------------------------------------------
// kdb_step
// Next-state and event logic for one scan tick.
// ----------------------------------------------------------------------------
`default_nettype none

module kdb_step #(
	parameter int unsigned HOLD_TIME_BITS = 20
) (
	input  kdb_pkg::kdb_cfg_t          cfg,
	input  kdb_pkg::kdb_ctl_t          ctl,
	input  logic [HOLD_TIME_BITS-1:0]  hold_time,
	input  logic                       raw_level,
	output kdb_pkg::kdb_ctl_t          ctl_nx,
	output logic [HOLD_TIME_BITS-1:0]  hold_time_nx,
	output kdb_pkg::kdb_res_t          res
);

	localparam int unsigned SUM_BITS = ((HOLD_TIME_BITS > 10) ? HOLD_TIME_BITS : 10) + 1;
	localparam int unsigned CMP_BITS = (HOLD_TIME_BITS > 20) ? HOLD_TIME_BITS : 20;

	logic [SUM_BITS-1:0]       hold_sum;
	logic [HOLD_TIME_BITS-1:0] hold_sat;
	logic [7:0]                run_bump;
	logic                      hold_reached;
	kdb_pkg::kdb_event_t       ev;

	assign hold_sum = SUM_BITS'(hold_time) + SUM_BITS'(cfg.tick_ms);
	// saturate at all ones
	assign hold_sat = (|hold_sum[SUM_BITS-1:HOLD_TIME_BITS]) ? '1
		: hold_sum[HOLD_TIME_BITS-1:0];
	assign hold_reached = CMP_BITS'(hold_sat) >= CMP_BITS'(cfg.max_hold_ms);
	assign run_bump = (ctl.stable_run == 8'hFF) ? 8'hFF : ctl.stable_run + 8'd1;

	always_comb begin
		ctl_nx       = ctl;
		hold_time_nx = hold_time;
		ev           = kdb_pkg::EV_NONE;
		unique case (ctl.fsm)
			kdb_pkg::ST_IDLE: begin
				if (raw_level) begin
					ctl_nx.stable_run = 8'd1;
					ctl_nx.fsm        = kdb_pkg::ST_DEB_PRESS;
				end
			end
			kdb_pkg::ST_DEB_PRESS: begin
				if (raw_level) begin
					ctl_nx.stable_run = run_bump;
					if (run_bump >= cfg.debounce_count) begin
						ctl_nx.fsm            = kdb_pkg::ST_PRESSED;
						ctl_nx.held_level     = 1'b1;
						ctl_nx.timeout_raised = 1'b0;
						hold_time_nx          = '0;
						ev                    = kdb_pkg::EV_PRESS;
					end
				end else begin
					ctl_nx.stable_run = 8'd0;
					ctl_nx.fsm        = kdb_pkg::ST_IDLE;
				end
			end
			kdb_pkg::ST_PRESSED: begin
				hold_time_nx = hold_sat;
				if (!raw_level) begin
					ctl_nx.stable_run = 8'd1;
					ctl_nx.fsm        = kdb_pkg::ST_DEB_RELEASE;
				end else if (hold_reached && !ctl.timeout_raised) begin
					// single timeout, then wait for a stable release
					ctl_nx.timeout_raised = 1'b1;
					ctl_nx.stable_run     = 8'd1;
					ctl_nx.fsm            = kdb_pkg::ST_DEB_RELEASE;
					ev                    = kdb_pkg::EV_TIMEOUT;
				end
			end
			kdb_pkg::ST_DEB_RELEASE: begin
				if (!raw_level) begin
					ctl_nx.stable_run = run_bump;
					if (run_bump >= cfg.debounce_count) begin
						ctl_nx.held_level     = 1'b0;
						ctl_nx.fsm            = kdb_pkg::ST_RELEASED;
						ctl_nx.timeout_raised = 1'b0;
						// suppress release after a timeout
						if (!ctl.timeout_raised) begin
							ev = kdb_pkg::EV_RELEASE;
						end
					end
				end else begin
					ctl_nx.stable_run = 8'd0;
					ctl_nx.fsm        = kdb_pkg::ST_PRESSED;
				end
			end
			default: begin
				// released and unused codes return to idle
				ctl_nx.fsm        = kdb_pkg::ST_IDLE;
				ctl_nx.stable_run = 8'd0;
			end
		endcase
	end

	assign res.event_code      = ev;
	assign res.debounced_level = ctl_nx.held_level;

endmodule

`default_nettype wire

// File: rtl/kdb_out_fifo.sv
// ----------------------------------------------------------------------------
// kdb_out_fifo
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module kdb_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  kdb_pkg::kdb_res_t push_word,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output kdb_pkg::kdb_res_t out_word
);

	kdb_pkg::kdb_res_t head_q;
	kdb_pkg::kdb_res_t skid_q;
	logic [1:0]        count_q;
	logic              pop;

	assign out_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop       = out_valid && !out_stall;
	assign out_word  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			// only reachable with one word held
			head_q <= push_word;
		end else if (push) begin
			if (count_q == 2'd0) begin
				head_q <= push_word;
			end else begin
				skid_q <= push_word;
			end
		end else if (pop) begin
			head_q <= skid_q;
		end
	end

	`KDB_ASSERT(a_count_max, clk, arst_n, count_q != 2'd3, "result buffer count overrun")
	`KDB_ASSERT_NEXT(a_full_drains, clk, arst_n, full && pop, count_q == 2'd1,
		"full buffer did not drain by one")

endmodule

`default_nettype wire

// File: rtl/key_debounce_with_hold_timeout_unit.sv
// ----------------------------------------------------------------------------
// key_debounce_with_hold_timeout_unit
// Debounces one key level per scan tick and reports press, release and
// hold timeout events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / raw_level) takes one raw key sample
//   per scan tick. Output channel (out_valid / out_stall / event_code /
//   debounced_level) returns exactly one word per sample, in order.
//   Each accepted sample updates the state registers and pushes its result word
//   into the result buffer together; the word is shown once older ones are taken.
//   Throughput is one sample per cycle while the buffer is not full: the state
//   update is a single pass through the next-state logic, and a two-entry result
//   buffer lets a new sample in while a finished word waits to be taken.
//   When the receiver stalls, the buffer fills; once both entries hold words
//   in_stall rises and stays high until the receiver takes one.
//   Configuration (cfg_we / cfg_index / cfg_data) writes debounce_count (0),
//   tick_ms (1) and max_hold_ms (2); other indexes are ignored. Write only
//   while the block is idle.
//   Reset clears the state machine to idle, empties the result buffer and
//   restores the register defaults (3, 20, 60000).
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module key_debounce_with_hold_timeout_unit #(
	parameter int unsigned HOLD_TIME_BITS = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [kdb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [kdb_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                raw_level,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          event_code,
	output logic                                debounced_level
);

	kdb_pkg::kdb_cfg_t         cfg_q;
	kdb_pkg::kdb_ctl_t         ctl_q;
	kdb_pkg::kdb_ctl_t         ctl_nx;
	logic [HOLD_TIME_BITS-1:0] hold_q;
	logic [HOLD_TIME_BITS-1:0] hold_nx;
	kdb_pkg::kdb_res_t         res;
	kdb_pkg::kdb_res_t         out_word;
	logic                      fifo_full;
	logic                      accept;

	assign in_stall = fifo_full;
	assign accept   = in_valid && !fifo_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_count <= kdb_pkg::DEBOUNCE_COUNT_RST;
			cfg_q.tick_ms        <= kdb_pkg::TICK_MS_RST;
			cfg_q.max_hold_ms    <= kdb_pkg::MAX_HOLD_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kdb_pkg::REG_DEBOUNCE_COUNT: cfg_q.debounce_count <= cfg_data[7:0];
				kdb_pkg::REG_TICK_MS:        cfg_q.tick_ms        <= cfg_data[9:0];
				kdb_pkg::REG_MAX_HOLD_MS:    cfg_q.max_hold_ms    <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.fsm            <= kdb_pkg::ST_IDLE;
			ctl_q.stable_run     <= 8'd0;
			ctl_q.held_level     <= 1'b0;
			ctl_q.timeout_raised <= 1'b0;
			hold_q               <= '0;
		end else if (accept) begin
			ctl_q  <= ctl_nx;
			hold_q <= hold_nx;
		end
	end

	kdb_step #(
		.HOLD_TIME_BITS(HOLD_TIME_BITS)
	) u_step (
		.cfg          (cfg_q),
		.ctl          (ctl_q),
		.hold_time    (hold_q),
		.raw_level    (raw_level),
		.ctl_nx       (ctl_nx),
		.hold_time_nx (hold_nx),
		.res          (res)
	);

	kdb_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_word (res),
		.full      (fifo_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	assign event_code      = out_word.event_code;
	assign debounced_level = out_word.debounced_level;

	`KDB_ASSERT(a_level_tracks_state, clk, arst_n,
		ctl_q.held_level == ((ctl_q.fsm == kdb_pkg::ST_PRESSED) ||
		(ctl_q.fsm == kdb_pkg::ST_DEB_RELEASE)),
		"debounced level out of step with state")
	`KDB_ASSERT_NEXT(a_timeout_moves, clk, arst_n,
		accept && (res.event_code == kdb_pkg::EV_TIMEOUT),
		(ctl_q.fsm == kdb_pkg::ST_DEB_RELEASE) && ctl_q.timeout_raised,
		"timeout word without release debounce")
	`KDB_ASSERT_NEXT(a_hold_idle, clk, arst_n, !accept, $stable(hold_q),
		"hold time moved without a sample")

endmodule

`default_nettype wire
